### src/tank_separation_sequencer_macros.svh
// Assertion macros used by the tank separation sequencer top level.
`ifndef TANK_SEPARATION_SEQUENCER_MACROS_SVH
`define TANK_SEPARATION_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Immediate implication checked on every clock edge outside reset.
`define TSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TSS_ASSERT_IMPL(label, ante, cons, msg)
`define TSS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### src/tss_pkg.sv
// Types and constants of the tank separation sequencer.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int unsigned RateW  = 16;
  localparam int unsigned LimitW = 15;
  localparam int unsigned DelayW = 24;
  localparam int unsigned DtW    = 16;
  localparam int unsigned ValveN = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [LimitW-1:0] RollLimitReset  = 15'd1280;
  localparam logic [LimitW-1:0] PitchLimitReset = 15'd179;
  localparam logic [LimitW-1:0] YawLimitReset   = 15'd179;
  localparam logic [DelayW-1:0] AutoDelayReset  = 24'd18000;
  localparam logic [DelayW-1:0] SepDelayReset   = 24'd160;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROLL_RATE_LIMIT          = 3'd0,
    CFG_PITCH_RATE_LIMIT         = 3'd1,
    CFG_YAW_RATE_LIMIT           = 3'd2,
    CFG_CUTOFF_TO_AUTO_DELAY     = 3'd3,
    CFG_TRANSLATION_TO_SEP_DELAY = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DtW-1:0]           elapsed_ms;
    logic                     cutoff_confirmed;
    logic                     manual_mode_switch;
    logic                     sep_pushbutton;
    logic signed [RateW-1:0]  roll_rate;
    logic signed [RateW-1:0]  pitch_rate;
    logic signed [RateW-1:0]  yaw_rate;
    logic [ValveN-1:0]        valve_closed_bits;
  } in_word_t;

  typedef struct packed {
    logic feedline_close_drive;
    logic feedline_open_drive;
    logic relief_isolation_close;
    logic translation_request;
    logic separate_request;
    logic sep_inhibited;
    logic sequence_active;
    logic sequence_done;
  } out_word_t;

endpackage

### src/tss_if.sv
// Valid/ready channel interfaces for the sequencer input and result words.
`timescale 1ns / 1ps

interface tss_in_if;
  logic              valid;
  logic              ready;
  tss_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tss_out_if;
  logic               valid;
  logic               ready;
  tss_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/tank_separation_sequencer.sv
// Top level of the interlocked tank separation sequencer.
`timescale 1ns / 1ps
`include "tank_separation_sequencer_macros.svh"

// One input word is one tick of the sequencer. A word is captured in an
// input register, the whole tick (countdown subtraction, rate and valve
// checks, sequencing) is evaluated in one pass of logic from that register
// and the held state, and the result word lands in an output register. The
// block takes one word per clock cycle when the result side keeps up. A
// word passes the input register, then the output register, where its
// result stays valid until the sink takes it. The two registers form a
// two-entry pipeline, so one new word is still taken into the input register
// while a finished result waits for the sink. The configuration port
// writes the rate limits and the two delays; write it only while no word is
// in flight. Once separation has been commanded the sequencer freezes and
// every later tick repeats the held line levels with both pulses low.
module tank_separation_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tss_pkg::CfgDataW-1:0]  cfg_data_i,
  tss_in_if.sink                        in_i,
  tss_out_if.source                     out_o
);

  localparam int unsigned LimitW = tss_pkg::LimitW;
  localparam int unsigned DelayW = tss_pkg::DelayW;
  localparam int unsigned RateW  = tss_pkg::RateW;
  localparam int unsigned DtW    = tss_pkg::DtW;

  // Configuration registers.
  logic [LimitW-1:0] roll_limit_q, pitch_limit_q, yaw_limit_q;
  logic [DelayW-1:0] auto_delay_q, sep_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_limit_q  <= tss_pkg::RollLimitReset;
      pitch_limit_q <= tss_pkg::PitchLimitReset;
      yaw_limit_q   <= tss_pkg::YawLimitReset;
      auto_delay_q  <= tss_pkg::AutoDelayReset;
      sep_delay_q   <= tss_pkg::SepDelayReset;
    end else if (cfg_we_i) begin
      unique case (tss_pkg::cfg_idx_e'(cfg_idx_i))
        tss_pkg::CFG_ROLL_RATE_LIMIT:          roll_limit_q  <= cfg_data_i[LimitW-1:0];
        tss_pkg::CFG_PITCH_RATE_LIMIT:         pitch_limit_q <= cfg_data_i[LimitW-1:0];
        tss_pkg::CFG_YAW_RATE_LIMIT:           yaw_limit_q   <= cfg_data_i[LimitW-1:0];
        tss_pkg::CFG_CUTOFF_TO_AUTO_DELAY:     auto_delay_q  <= cfg_data_i[DelayW-1:0];
        tss_pkg::CFG_TRANSLATION_TO_SEP_DELAY: sep_delay_q   <= cfg_data_i[DelayW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. The tick is evaluated when the input register holds
  // a word and the output register is empty or being drained this cycle.
  logic              in_valid_q;
  tss_pkg::in_word_t in_word_q;
  logic              out_valid_q;
  tss_pkg::out_word_t out_word_q;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_word_q <= in_i.payload;
    end
  end

  // Sequencer state, including the held levels of the three valve lines.
  logic              armed_q, finished_q, auto_q, cmd_q, started_q, inhibit_q;
  logic [DelayW-1:0] cutoff_cd_q, sep_cd_q;
  logic              close_q, open_q, relief_q;

  logic              armed_d, finished_d, auto_d, cmd_d, started_d, inhibit_d;
  logic [DelayW-1:0] cutoff_cd_d, sep_cd_d;
  logic              close_d, open_d, relief_d;
  logic              trans_pulse, sep_pulse, checks_pass;

  // Absolute value of a signed rate; the most negative code gives 32768.
  function automatic logic [RateW:0] abs_rate(logic signed [RateW-1:0] r);
    logic [RateW:0] ext;
    ext = {1'b0, r};
    return r[RateW-1] ? (({1'b1, {RateW{1'b0}}}) - ext) : ext;
  endfunction

  // Countdown step that stops at zero instead of wrapping.
  function automatic logic [DelayW-1:0] count_down(logic [DelayW-1:0] c,
                                                   logic [DtW-1:0] dt);
    logic [DelayW:0] diff;
    diff = {1'b0, c} - {{(DelayW+1-DtW){1'b0}}, dt};
    return diff[DelayW] ? '0 : diff[DelayW-1:0];
  endfunction

  always_comb begin
    checks_pass =
      (abs_rate(in_word_q.roll_rate)  <= {{(RateW+1-LimitW){1'b0}}, roll_limit_q})  &&
      (abs_rate(in_word_q.pitch_rate) <= {{(RateW+1-LimitW){1'b0}}, pitch_limit_q}) &&
      (abs_rate(in_word_q.yaw_rate)   <= {{(RateW+1-LimitW){1'b0}}, yaw_limit_q})   &&
      (&in_word_q.valve_closed_bits);
  end

  always_comb begin
    armed_d     = armed_q;
    finished_d  = finished_q;
    auto_d      = auto_q;
    cmd_d       = cmd_q;
    started_d   = started_q;
    inhibit_d   = inhibit_q;
    cutoff_cd_d = cutoff_cd_q;
    sep_cd_d    = sep_cd_q;
    close_d     = close_q;
    open_d      = open_q;
    relief_d    = relief_q;
    trans_pulse = 1'b0;
    sep_pulse   = 1'b0;

    if (!finished_q) begin
      if (armed_q) begin
        cutoff_cd_d = count_down(cutoff_cd_q, in_word_q.elapsed_ms);
        if (started_q) begin
          sep_cd_d = count_down(sep_cd_q, in_word_q.elapsed_ms);
        end

        // Manual mode waits for the pushbutton; otherwise the expired
        // countdown latches auto mode for good.
        if (in_word_q.manual_mode_switch) begin
          if (in_word_q.sep_pushbutton) begin
            cmd_d = 1'b1;
          end
        end else if (cutoff_cd_d == '0) begin
          auto_d = 1'b1;
        end

        close_d  = 1'b1;
        open_d   = 1'b0;
        relief_d = 1'b0;

        if (auto_d) begin
          if (checks_pass) begin
            cmd_d   = 1'b1;
            close_d = 1'b0;
          end else begin
            inhibit_d = 1'b1;
          end
        end

        // The first commanded tick requests translation and loads the
        // separation delay; separation fires once that delay has run out.
        if (cmd_d) begin
          if (!started_q) begin
            trans_pulse = 1'b1;
            sep_cd_d    = sep_delay_q;
            started_d   = 1'b1;
          end else if (sep_cd_d == '0) begin
            sep_pulse  = 1'b1;
            inhibit_d  = 1'b0;
            finished_d = 1'b1;
          end
        end
      end else if (in_word_q.cutoff_confirmed) begin
        cutoff_cd_d = auto_delay_q;
        armed_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      finished_q  <= 1'b0;
      auto_q      <= 1'b0;
      cmd_q       <= 1'b0;
      started_q   <= 1'b0;
      inhibit_q   <= 1'b0;
      cutoff_cd_q <= '0;
      sep_cd_q    <= '0;
      close_q     <= 1'b0;
      open_q      <= 1'b1;
      relief_q    <= 1'b1;
    end else if (advance) begin
      armed_q     <= armed_d;
      finished_q  <= finished_d;
      auto_q      <= auto_d;
      cmd_q       <= cmd_d;
      started_q   <= started_d;
      inhibit_q   <= inhibit_d;
      cutoff_cd_q <= cutoff_cd_d;
      sep_cd_q    <= sep_cd_d;
      close_q     <= close_d;
      open_q      <= open_d;
      relief_q    <= relief_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q.feedline_close_drive   <= close_d;
      out_word_q.feedline_open_drive    <= open_d;
      out_word_q.relief_isolation_close <= relief_d;
      out_word_q.translation_request    <= trans_pulse;
      out_word_q.separate_request       <= sep_pulse;
      out_word_q.sep_inhibited          <= inhibit_d;
      out_word_q.sequence_active        <= armed_d;
      out_word_q.sequence_done          <= finished_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

  `TSS_ASSERT_NEXT(finished_sticks_a, finished_q, finished_q,
                   "finished state was left")
  `TSS_ASSERT_IMPL(finished_needs_armed_a, finished_q, armed_q && started_q,
                   "finished without arming and translation")
  `TSS_ASSERT_IMPL(sep_after_trans_a, advance && sep_pulse, started_q && !trans_pulse,
                   "separate pulse without prior translation")
  `TSS_ASSERT_NEXT(trans_starts_timer_a, advance && trans_pulse, started_q && !finished_q,
                   "translation did not start the separation timer")
  `TSS_ASSERT_IMPL(done_implies_active_a, out_valid_q,
                   !out_word_q.sequence_done || out_word_q.sequence_active,
                   "result reports done while not active")

endmodule
